// ===== src/mmbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mmbd_pkg
// Shared constants, types and helpers of the 2x2 box downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package mmbd_pkg;

  localparam int MAX_SRC_WIDTH  = 4096;
  localparam int MAX_SRC_HEIGHT = 4096;

  localparam int CHAN_W     = 8;
  localparam int PAIR_W     = CHAN_W + 1;
  localparam int QUAD_W     = CHAN_W + 2;
  localparam int SIZE_W     = 13;
  localparam int COL_W      = $clog2(MAX_SRC_WIDTH);
  localparam int ROW_W      = $clog2(MAX_SRC_HEIGHT);
  localparam int LINE_DEPTH = MAX_SRC_WIDTH / 2;
  localparam int LINE_IDX_W = $clog2(LINE_DEPTH);

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic REG_SRC_WIDTH  = 1'b0;
  localparam logic REG_SRC_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] SRC_SIZE_RESET = SIZE_W'(256);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [PAIR_W-1:0] alpha;
    logic [PAIR_W-1:0] blue;
    logic [PAIR_W-1:0] green;
    logic [PAIR_W-1:0] red;
  } pair_sum_t;

  localparam int PAIR_SUM_W = $bits(pair_sum_t);

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] raw,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] res;
    if (raw < SIZE_W'(2)) begin
      res = SIZE_W'(2);
    end else if (raw > hi) begin
      res = hi;
    end else begin
      res = raw;
    end
    return res;
  endfunction

  function automatic logic [CHAN_W-1:0] quad_mean(input logic [PAIR_W-1:0] a,
                                                  input logic [PAIR_W-1:0] b);
    logic [QUAD_W-1:0] s;
    s = QUAD_W'(a) + QUAD_W'(b);
    return s[QUAD_W-1:2];
  endfunction

endpackage

`default_nettype wire

// ===== src/mmbd_line_buf.sv =====
// ----------------------------------------------------------------------------
// mmbd_line_buf
// Line buffer of pair sums from the even source row, one entry per column
// pair, single write port and single registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mmbd_line_buf (
  input  wire                                  clk,
  input  wire                                  wr_en,
  input  wire  [mmbd_pkg::LINE_IDX_W-1:0]      wr_idx,
  input  wire  mmbd_pkg::pair_sum_t            wr_data,
  input  wire                                  rd_en,
  input  wire  [mmbd_pkg::LINE_IDX_W-1:0]      rd_idx,
  output mmbd_pkg::pair_sum_t                  rd_data
);

  logic [mmbd_pkg::PAIR_SUM_W-1:0] mem [mmbd_pkg::LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mmbd_pkg::pair_sum_t'(mem[rd_idx]);
    end
  end

endmodule

`default_nettype wire

// ===== src/mipmap_box_downsample.sv =====
// ----------------------------------------------------------------------------
// mipmap_box_downsample
// 2x2 box filter that halves one mip level of an RGBA image.
//
// Source pixels enter on the in_* channel in raster order, one transaction
// per pixel. Each 2x2 block gives one result transaction on the out_*
// channel, issued after the odd column of the odd row; frame_last marks the
// final result of the level. A trailing odd row or column is consumed and
// dropped. The APB port sets src_width (0x0) and src_height (0x4); a write
// also restarts the level at column 0, row 0.
// Throughput: one pixel per cycle while in_ready is high. After its last
// pixel is accepted, a result is registered by the line buffer memory read
// and the read stage, then by the output register.
// When out_ready is low the result holds in the output register and one
// more result waits in the read stage; in_ready drops only when both are
// full. Reset clears the counters, the held pixel and both stages and sets
// both sizes to 256; the line buffer needs no clearing since every odd row
// reads entries its even row wrote.
// ----------------------------------------------------------------------------
`default_nettype none

module mipmap_box_downsample (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [mmbd_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire  [mmbd_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [mmbd_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [mmbd_pkg::CHAN_W-1:0]          in_red,
  input  wire  [mmbd_pkg::CHAN_W-1:0]          in_green,
  input  wire  [mmbd_pkg::CHAN_W-1:0]          in_blue,
  input  wire  [mmbd_pkg::CHAN_W-1:0]          in_alpha,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [mmbd_pkg::CHAN_W-1:0]          out_red,
  output logic [mmbd_pkg::CHAN_W-1:0]          out_green,
  output logic [mmbd_pkg::CHAN_W-1:0]          out_blue,
  output logic [mmbd_pkg::CHAN_W-1:0]          out_alpha,
  output logic                                 frame_last
);

  logic [mmbd_pkg::SIZE_W-1:0] src_width;
  logic [mmbd_pkg::SIZE_W-1:0] src_height;
  logic [mmbd_pkg::SIZE_W-1:0] w_eff;
  logic [mmbd_pkg::SIZE_W-1:0] h_eff;
  logic [mmbd_pkg::SIZE_W-1:0] last_col;
  logic [mmbd_pkg::SIZE_W-1:0] last_row;
  logic [mmbd_pkg::SIZE_W-1:0] col_inc;
  logic [mmbd_pkg::SIZE_W-1:0] row_inc;

  logic [mmbd_pkg::COL_W-1:0] column_count;
  logic [mmbd_pkg::ROW_W-1:0] row_count;
  mmbd_pkg::pixel_t           held_left_pixel;
  mmbd_pkg::pixel_t           pix;
  mmbd_pkg::pair_sum_t        pair;
  mmbd_pkg::pair_sum_t        above;

  logic cfg_wr;
  logic in_fire;
  logic line_wr;
  logic line_rd;
  logic is_last;

  logic                s1_valid;
  logic                s1_last;
  mmbd_pkg::pair_sum_t s1_pair;
  logic                s1_go;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= mmbd_pkg::SRC_SIZE_RESET;
      src_height <= mmbd_pkg::SRC_SIZE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        mmbd_pkg::REG_SRC_WIDTH:  src_width  <= pwdata[mmbd_pkg::SIZE_W-1:0];
        mmbd_pkg::REG_SRC_HEIGHT: src_height <= pwdata[mmbd_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mmbd_pkg::REG_SRC_WIDTH:  prdata = mmbd_pkg::APB_DATA_W'(src_width);
      mmbd_pkg::REG_SRC_HEIGHT: prdata = mmbd_pkg::APB_DATA_W'(src_height);
      default:                  prdata = '0;
    endcase
  end

  assign w_eff = mmbd_pkg::clamp_size(src_width, mmbd_pkg::SIZE_W'(mmbd_pkg::MAX_SRC_WIDTH));
  assign h_eff = mmbd_pkg::clamp_size(src_height,
                                      mmbd_pkg::SIZE_W'(mmbd_pkg::MAX_SRC_HEIGHT));
  assign last_col = {w_eff[mmbd_pkg::SIZE_W-1:1], 1'b0} - mmbd_pkg::SIZE_W'(1);
  assign last_row = {h_eff[mmbd_pkg::SIZE_W-1:1], 1'b0} - mmbd_pkg::SIZE_W'(1);

  // input side: pair sums and raster counters
  assign s1_go    = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_go;
  assign in_fire  = in_valid && in_ready;

  assign pix = '{red: in_red, green: in_green, blue: in_blue, alpha: in_alpha};

  always_comb begin
    pair.red   = mmbd_pkg::PAIR_W'(held_left_pixel.red)   + mmbd_pkg::PAIR_W'(pix.red);
    pair.green = mmbd_pkg::PAIR_W'(held_left_pixel.green) + mmbd_pkg::PAIR_W'(pix.green);
    pair.blue  = mmbd_pkg::PAIR_W'(held_left_pixel.blue)  + mmbd_pkg::PAIR_W'(pix.blue);
    pair.alpha = mmbd_pkg::PAIR_W'(held_left_pixel.alpha) + mmbd_pkg::PAIR_W'(pix.alpha);
  end

  assign line_wr = in_fire && column_count[0] && !row_count[0];
  assign line_rd = in_fire && column_count[0] && row_count[0];
  assign is_last = (mmbd_pkg::SIZE_W'(column_count) == last_col) &&
                   (mmbd_pkg::SIZE_W'(row_count) == last_row);

  assign col_inc = mmbd_pkg::SIZE_W'(column_count) + mmbd_pkg::SIZE_W'(1);
  assign row_inc = mmbd_pkg::SIZE_W'(row_count) + mmbd_pkg::SIZE_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      held_left_pixel <= '0;
    end else if (cfg_wr) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_fire) begin
      if (!column_count[0]) begin
        held_left_pixel <= pix;
      end
      if (col_inc >= w_eff) begin
        column_count <= '0;
        if (row_inc >= h_eff) begin
          row_count <= '0;
        end else begin
          row_count <= row_inc[mmbd_pkg::ROW_W-1:0];
        end
      end else begin
        column_count <= col_inc[mmbd_pkg::COL_W-1:0];
      end
    end
  end

  mmbd_line_buf u_line_buf (
    .clk     (clk),
    .wr_en   (line_wr),
    .wr_idx  (column_count[mmbd_pkg::COL_W-1:1]),
    .wr_data (pair),
    .rd_en   (line_rd),
    .rd_idx  (column_count[mmbd_pkg::COL_W-1:1]),
    .rd_data (above)
  );

  // read stage: wait for the line entry above
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= line_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (line_rd) begin
      s1_pair <= pair;
      s1_last <= is_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_valid) begin
      out_red    <= mmbd_pkg::quad_mean(above.red,   s1_pair.red);
      out_green  <= mmbd_pkg::quad_mean(above.green, s1_pair.green);
      out_blue   <= mmbd_pkg::quad_mean(above.blue,  s1_pair.blue);
      out_alpha  <= mmbd_pkg::quad_mean(above.alpha, s1_pair.alpha);
      frame_last <= s1_last;
    end
  end

endmodule

`default_nettype wire

// ===== src/mmbd_checker.sv =====
// ----------------------------------------------------------------------------
// mmbd_checker
// Port-level checks of the box downsampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mmbd_checker (
  input wire                         clk,
  input wire                         rst,
  input wire                         in_valid,
  input wire                         in_ready,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire [mmbd_pkg::CHAN_W-1:0]  out_red,
  input wire [mmbd_pkg::CHAN_W-1:0]  out_green,
  input wire [mmbd_pkg::CHAN_W-1:0]  out_blue,
  input wire [mmbd_pkg::CHAN_W-1:0]  out_alpha,
  input wire                         frame_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_red) && $stable(out_green) &&
      $stable(out_blue) && $stable(out_alpha) && $stable(frame_last))
    else $error("result payload changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without an input transaction two cycles before");

endmodule

bind mipmap_box_downsample mmbd_checker u_mmbd_checker (.*);

`default_nettype wire
